// ===== rtl/rsst_pkg.sv =====
// rsst_pkg: shared codes, widths and reset values for the relay start/stop cycle timer
// no dependencies; used by the channel interfaces, the top level and the checker

package rsst_pkg;

    // payload field widths
    localparam int FUNC_W   = 2;
    localparam int TIME_W   = 32;
    localparam int PHASE_W  = 4;
    localparam int COUNT_W  = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // parameter defaults
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    // register reset values
    localparam logic [CFG_W-1:0] SETTLE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] PULSE_RESET  = 16'd200;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE  = 1'd1;

    typedef logic [FUNC_W-1:0]  t_func;
    typedef logic [PHASE_W-1:0] t_phase;

    // command codes
    localparam t_func FUNC_TICK     = 2'd0;
    localparam t_func FUNC_START    = 2'd1;
    localparam t_func FUNC_START_SP = 2'd2;
    localparam t_func FUNC_STOP     = 2'd3;

    // phase codes
    localparam t_phase PH_IDLE        = 4'd0;
    localparam t_phase PH_SETTLE      = 4'd1;
    localparam t_phase PH_SETTLE_STOP = 4'd2;
    localparam t_phase PH_START_PULSE = 4'd3;
    localparam t_phase PH_RUN         = 4'd4;
    localparam t_phase PH_STOP_PULSE  = 4'd5;
    localparam t_phase PH_PAUSE       = 4'd6;
    localparam t_phase PH_END_SETTLE  = 4'd7;
    localparam t_phase PH_END_STOP    = 4'd8;

endpackage

// ===== rtl/rsst_if.sv =====
// rsst_in_if / rsst_out_if: valid/ready channels of the relay cycle timer
// depends on rsst_pkg for field types and widths

interface rsst_in_if;
    logic                        valid;
    logic                        ready;
    rsst_pkg::t_func             func;
    logic [rsst_pkg::TIME_W-1:0] run_time;
    logic [rsst_pkg::TIME_W-1:0] pause_time;

    modport source (output valid, output func, output run_time, output pause_time,
                    input ready);
    modport sink   (input valid, input func, input run_time, input pause_time,
                    output ready);
endinterface

interface rsst_out_if;
    logic                         valid;
    logic                         ready;
    logic                         start_relay;
    logic                         stop_relay;
    rsst_pkg::t_phase             phase;
    logic                         running;
    logic [rsst_pkg::TIME_W-1:0]  phase_time;
    logic [rsst_pkg::COUNT_W-1:0] start_count;
    logic [rsst_pkg::COUNT_W-1:0] stop_count;
    logic [rsst_pkg::COUNT_W-1:0] round_count;

    modport source (output valid, output start_relay, output stop_relay, output phase,
                    output running, output phase_time, output start_count,
                    output stop_count, output round_count, input ready);
    modport sink   (input valid, input start_relay, input stop_relay, input phase,
                    input running, input phase_time, input start_count,
                    input stop_count, input round_count, output ready);
endinterface

// ===== rtl/relay_start_stop_cycle_timer_top.sv =====
// relay_start_stop_cycle_timer_top: tick-driven START/STOP relay cycle sequencer
// depends on rsst_pkg and the channel interfaces in rsst_if.sv
//
//  channel   dir   beat contents                                     handshake
//  i_in      in    func, run_time, pause_time                        valid/ready
//  o_out     out   relays, phase, running, phase_time, 3 counters    valid/ready
//  cfg       in    i_cfg_we, i_cfg_idx, i_cfg_data                   write strobe
//
// one beat in, one beat out; the result is registered and appears in the cycle after the input beat
// the state registers are the output register: a new beat is taken whenever the
// output is empty or is being taken in the same cycle, so one beat per cycle sustained
// the per-beat path is one saturating increment and one compare against the phase limit
// a stall on o_out holds the result and back-pressures i_in in the same cycle
// synchronous active-low reset: idle, relays off, counters and timer zero, settle 50, pulse 200

module relay_start_stop_cycle_timer_top #(
    parameter int TIME_WIDTH  = rsst_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = rsst_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rsst_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rsst_pkg::CFG_W-1:0]       i_cfg_data,
    rsst_in_if.sink                          i_in,
    rsst_out_if.source                       o_out
);

    // largest timer value, at port width
    localparam logic [rsst_pkg::TIME_W-1:0] TimeMaxW =
        rsst_pkg::TIME_W'((33'd1 << TIME_WIDTH) - 33'd1);
    localparam logic [TIME_WIDTH-1:0] TimeMax = TimeMaxW[TIME_WIDTH-1:0];

    // configuration registers
    logic [rsst_pkg::CFG_W-1:0] r_settle;
    logic [rsst_pkg::CFG_W-1:0] r_pulse;

    // sequencer state, doubles as the result register
    rsst_pkg::t_phase       r_phase,    n_phase;
    logic [TIME_WIDTH-1:0]  r_elapsed,  n_elapsed;
    logic [TIME_WIDTH-1:0]  r_run_len,  n_run_len;
    logic [TIME_WIDTH-1:0]  r_pause_len, n_pause_len;
    logic                   r_start_on, n_start_on;
    logic                   r_stop_on,  n_stop_on;
    logic [COUNT_WIDTH-1:0] r_starts,   n_starts;
    logic [COUNT_WIDTH-1:0] r_stops,    n_stops;
    logic [COUNT_WIDTH-1:0] r_rounds,   n_rounds;
    logic                   r_out_valid;

    logic                   in_take;
    logic [TIME_WIDTH-1:0]  el_inc;
    logic [TIME_WIDTH-1:0]  settle_lim;
    logic [TIME_WIDTH-1:0]  pulse_lim;
    logic [TIME_WIDTH-1:0]  run_sat;
    logic [TIME_WIDTH-1:0]  pause_sat;

    // output empty or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;

    // config writes, taken on any cycle with the write enable high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= rsst_pkg::SETTLE_RESET;
            r_pulse  <= rsst_pkg::PULSE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rsst_pkg::CFG_SETTLE: r_settle <= i_cfg_data;
                rsst_pkg::CFG_PULSE:  r_pulse  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign settle_lim = TIME_WIDTH'(r_settle);
    assign pulse_lim  = TIME_WIDTH'(r_pulse);

    // saturating timer step
    assign el_inc = (r_elapsed != TimeMax) ? r_elapsed + 1'b1 : r_elapsed;

    // lengths clamp to the timer range so a saturated timer still reaches them
    assign run_sat   = (i_in.run_time > TimeMaxW) ? TimeMax
                                                  : i_in.run_time[TIME_WIDTH-1:0];
    assign pause_sat = (i_in.pause_time > TimeMaxW) ? TimeMax
                                                    : i_in.pause_time[TIME_WIDTH-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_run_len   = r_run_len;
        n_pause_len = r_pause_len;
        n_start_on  = r_start_on;
        n_stop_on   = r_stop_on;
        n_starts    = r_starts;
        n_stops     = r_stops;
        n_rounds    = r_rounds;
        case (i_in.func)
            rsst_pkg::FUNC_TICK: begin
                if (r_phase != rsst_pkg::PH_IDLE) begin
                    n_elapsed = el_inc;
                    case (r_phase)
                        rsst_pkg::PH_SETTLE: begin
                            if (el_inc >= settle_lim) begin
                                n_start_on = 1'b1;
                                n_phase    = rsst_pkg::PH_START_PULSE;
                                n_elapsed  = '0;
                            end
                        end
                        rsst_pkg::PH_SETTLE_STOP: begin
                            if (el_inc >= settle_lim) begin
                                n_stop_on = 1'b1;
                                n_phase   = rsst_pkg::PH_STOP_PULSE;
                                n_elapsed = '0;
                            end
                        end
                        rsst_pkg::PH_START_PULSE: begin
                            if (el_inc >= pulse_lim) begin
                                n_start_on = 1'b0;
                                n_phase    = rsst_pkg::PH_RUN;
                                n_elapsed  = '0;
                            end
                        end
                        rsst_pkg::PH_RUN: begin
                            if (el_inc >= r_run_len) begin
                                n_stop_on = 1'b1;
                                n_phase   = rsst_pkg::PH_STOP_PULSE;
                                n_elapsed = '0;
                            end
                        end
                        rsst_pkg::PH_STOP_PULSE: begin
                            if (el_inc >= pulse_lim) begin
                                n_stop_on = 1'b0;
                                n_phase   = rsst_pkg::PH_PAUSE;
                                n_elapsed = '0;
                            end
                        end
                        rsst_pkg::PH_PAUSE: begin
                            // end of pause closes a round
                            if (el_inc >= r_pause_len) begin
                                n_rounds   = r_rounds + 1'b1;
                                n_start_on = 1'b1;
                                n_phase    = rsst_pkg::PH_START_PULSE;
                                n_elapsed  = '0;
                            end
                        end
                        rsst_pkg::PH_END_SETTLE: begin
                            if (el_inc >= settle_lim) begin
                                n_stop_on = 1'b1;
                                n_phase   = rsst_pkg::PH_END_STOP;
                                n_elapsed = '0;
                            end
                        end
                        rsst_pkg::PH_END_STOP: begin
                            if (el_inc >= pulse_lim) begin
                                n_stop_on = 1'b0;
                                n_phase   = rsst_pkg::PH_IDLE;
                                n_elapsed = '0;
                            end
                        end
                        default: ; // unused codes only advance the timer
                    endcase
                end
            end
            rsst_pkg::FUNC_START, rsst_pkg::FUNC_START_SP: begin
                // start from any phase
                n_run_len   = run_sat;
                n_pause_len = pause_sat;
                n_starts    = r_starts + 1'b1;
                n_start_on  = 1'b0;
                n_stop_on   = 1'b0;
                n_elapsed   = '0;
                n_phase     = (i_in.func == rsst_pkg::FUNC_START) ? rsst_pkg::PH_SETTLE
                                                                  : rsst_pkg::PH_SETTLE_STOP;
            end
            rsst_pkg::FUNC_STOP: begin
                // ignored once idle or already winding down
                if (r_phase != rsst_pkg::PH_IDLE && r_phase != rsst_pkg::PH_END_SETTLE &&
                    r_phase != rsst_pkg::PH_END_STOP) begin
                    n_stops    = r_stops + 1'b1;
                    n_start_on = 1'b0;
                    n_stop_on  = 1'b0;
                    n_elapsed  = '0;
                    n_phase    = rsst_pkg::PH_END_SETTLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rsst_pkg::PH_IDLE;
            r_elapsed   <= '0;
            r_run_len   <= '0;
            r_pause_len <= '0;
            r_start_on  <= 1'b0;
            r_stop_on   <= 1'b0;
            r_starts    <= '0;
            r_stops     <= '0;
            r_rounds    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_phase     <= n_phase;
                r_elapsed   <= n_elapsed;
                r_run_len   <= n_run_len;
                r_pause_len <= n_pause_len;
                r_start_on  <= n_start_on;
                r_stop_on   <= n_stop_on;
                r_starts    <= n_starts;
                r_stops     <= n_stops;
                r_rounds    <= n_rounds;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result beat is the state after the last accepted item
    assign o_out.valid       = r_out_valid;
    assign o_out.start_relay = r_start_on;
    assign o_out.stop_relay  = r_stop_on;
    assign o_out.phase       = r_phase;
    assign o_out.running     = (r_phase != rsst_pkg::PH_IDLE);
    assign o_out.phase_time  = rsst_pkg::TIME_W'(r_elapsed);
    assign o_out.start_count = rsst_pkg::COUNT_W'(r_starts);
    assign o_out.stop_count  = rsst_pkg::COUNT_W'(r_stops);
    assign o_out.round_count = rsst_pkg::COUNT_W'(r_rounds);

endmodule

// ===== rtl/rsst_checker.sv =====
// rsst_checker: port-level checks on the relay cycle timer, bound to the top level
// depends on rsst_pkg and relay_start_stop_cycle_timer_top

module rsst_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_start_relay,
    input logic                          i_stop_relay,
    input rsst_pkg::t_phase              i_phase,
    input logic                          i_running,
    input logic [rsst_pkg::TIME_W-1:0]   i_phase_time
);

    // every accepted beat yields a result next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted beat gave no result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_phase) && $stable(i_phase_time)))
        else $error("stalled result changed");

    // never both relays pressed
    a_relay_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_start_relay && i_stop_relay))
        else $error("both relays energized");

    // running flag follows phase, no relay while idle
    a_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_running == (i_phase != rsst_pkg::PH_IDLE)) &&
                         (i_running || (!i_start_relay && !i_stop_relay &&
                                        i_phase_time == '0))))
        else $error("running flag or idle outputs wrong");

endmodule

bind relay_start_stop_cycle_timer_top rsst_checker u_rsst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_start_relay (o_out.start_relay),
    .i_stop_relay  (o_out.stop_relay),
    .i_phase       (o_out.phase),
    .i_running     (o_out.running),
    .i_phase_time  (o_out.phase_time)
);
